@@ sv/mftt_pkg.sv @@
// Shared types and constants for the motor feedback turn tracker.
// No dependencies; used by motor_feedback_turn_tracker.
package mftt_pkg;

  localparam int unsigned IdW      = 11;
  localparam int unsigned AngW     = 16;
  localparam int unsigned CntW     = 6;
  localparam int unsigned CurW     = 14;
  localparam int unsigned TurnW    = 32;
  localparam int unsigned TotW     = 46;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 11;

  localparam logic [CfgIdxW-1:0] CFG_BASE_ID     = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_INIT_FRAMES = 2'd1;

  localparam logic [IdW-1:0]  BASE_ID_RST     = 11'd513;
  localparam logic [CntW-1:0] INIT_FRAMES_RST = 6'd50;
  localparam logic [CntW-1:0] CNT_MAX         = 6'd63;

  // unwrap thresholds in angle counts, half of the 8192 counts per turn
  localparam logic signed [AngW:0] STEP_HI = 17'sd4096;
  localparam logic signed [AngW:0] STEP_LO = -17'sd4096;

  // reciprocal for divide by 5 on magnitudes up to 2^16
  localparam logic [16:0] RECIP5  = 17'd52429;
  localparam int unsigned RECIP_SH = 18;

  // per-motor record kept in the state memory
  typedef struct packed {
    logic [CntW-1:0]         cnt;
    logic [AngW-1:0]         angle;
    logic [AngW-1:0]         offset;
    logic [TurnW-1:0]        turns;
    logic [15:0]             speed;
    logic [CurW-1:0]         current;
    logic [7:0]              temp;
    logic [TotW-1:0]         total;
  } rec_t;

endpackage

@@ sv/motor_feedback_turn_tracker.sv @@
// Motor feedback turn tracker: per-motor multi-turn angle unwrap.
// Depends on mftt_pkg (types, widths, constants).
//
// Usage:
//   Input channel (in_valid_i/in_ready_o) takes one feedback frame item per
//   cycle while in_ready_o is high: identifier, raw angle, speed, current,
//   temperature. The motor index is frame_id_i - base_id; frames outside
//   0..MOTOR_COUNT-1 are accepted and dropped without a result.
//   Output channel (out_valid_o/out_ready_i) gives one result item per
//   served frame, from the stage 1 register through the output register.
//   It carries the low motor index bit and the stored record of that motor
//   after the update (all but cnt and offset), plus the in-init flag.
//   Config channel (cfg_valid_i/cfg_ready_o) is always ready; index 0 is
//   base_id, index 1 is init_frames, other indices are ignored.
// Throughput: one item per cycle sustained while the output register is
//   not held. Stage 0 issues the memory read (and does the divide by -5 on
//   the current); stage 1 does the read-modify-write. A write to the same
//   motor in the cycle of a read is forwarded from the write-back register.
// Stall: when the output register is full and not taken, stage 1 holds; if
//   stage 1 holds an item, in_ready_o drops in that same cycle. Nothing is lost.
// Reset: config returns to defaults, all per-entry valid bits clear so every
//   motor reads as an all-zero record; no clearing pass is needed.
module motor_feedback_turn_tracker #(
  parameter int unsigned MOTOR_COUNT = 2
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,

  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [10:0]                   frame_id_i,
  input  logic [15:0]                   angle_raw_i,
  input  logic signed [15:0]            speed_raw_i,
  input  logic signed [15:0]            current_raw_i,
  input  logic [7:0]                    temp_raw_i,

  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          motor_index_o,
  output logic                          in_init_o,
  output logic [15:0]                   angle_now_o,
  output logic signed [15:0]            speed_now_o,
  output logic signed [13:0]            current_now_o,
  output logic [7:0]                    temp_now_o,
  output logic signed [31:0]            turns_o,
  output logic signed [45:0]            multiturn_pos_o,

  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [mftt_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [mftt_pkg::CfgDataW-1:0] cfg_data_i
);

  localparam int unsigned IdxW = (MOTOR_COUNT > 1) ? $clog2(MOTOR_COUNT) : 1;

  // ---------------- configuration ----------------
  logic [mftt_pkg::IdW-1:0]  base_id_q;
  logic [mftt_pkg::CntW-1:0] init_frames_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_id_q     <= mftt_pkg::BASE_ID_RST;
      init_frames_q <= mftt_pkg::INIT_FRAMES_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        mftt_pkg::CFG_BASE_ID:     base_id_q     <= cfg_data_i[mftt_pkg::IdW-1:0];
        mftt_pkg::CFG_INIT_FRAMES: init_frames_q <= cfg_data_i[mftt_pkg::CntW-1:0];
        default: ;
      endcase
    end
  end

  // ---------------- stage 0: decode, divide, memory read ----------------
  logic                      in_acc;
  logic [mftt_pkg::IdW:0]    id_diff;
  logic                      id_hit;
  logic [IdxW-1:0]           in_idx;
  logic [16:0]               cur_mag;
  logic [33:0]               cur_prod;
  logic [12:0]               cur_quot;
  logic [mftt_pkg::CurW-1:0] cur_val;

  logic                      s1_vld_q;
  logic                      s1_adv;
  logic                      wr_en;

  assign s1_adv     = !out_valid_o || out_ready_i;
  assign in_ready_o = !s1_vld_q || s1_adv;
  assign in_acc     = in_valid_i && in_ready_o;

  // unsigned compare handles ids below the base: the borrow sets the top bit
  assign id_diff = {1'b0, frame_id_i} - {1'b0, base_id_q};
  assign id_hit  = (id_diff < (mftt_pkg::IdW+1)'(MOTOR_COUNT));
  assign in_idx  = id_diff[IdxW-1:0];

  // |raw| / 5 by reciprocal, sign flipped (divide by -5, toward zero)
  assign cur_mag  = current_raw_i[15] ? (17'd0 - {current_raw_i[15], current_raw_i})
                                      : {1'b0, current_raw_i};
  assign cur_prod = cur_mag * mftt_pkg::RECIP5;
  assign cur_quot = cur_prod[mftt_pkg::RECIP_SH +: 13];
  assign cur_val  = current_raw_i[15] ? {1'b0, cur_quot}
                                      : (mftt_pkg::CurW'(0) - {1'b0, cur_quot});

  // stage 1 payload
  logic [IdxW-1:0]           s1_idx_q;
  logic [mftt_pkg::AngW-1:0] s1_ang_q;
  logic [15:0]               s1_speed_q;
  logic [mftt_pkg::CurW-1:0] s1_cur_q;
  logic [7:0]                s1_temp_q;
  logic                      s1_fwd_q;
  logic                      s1_rvld_q;

  // state memory and write-back register
  mftt_pkg::rec_t            mem_q [MOTOR_COUNT];
  mftt_pkg::rec_t            rdata_q;
  mftt_pkg::rec_t            wb_q;
  mftt_pkg::rec_t            new_rec;
  logic [MOTOR_COUNT-1:0]    ent_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      ent_vld_q <= '0;
    end else begin
      if (in_ready_o) s1_vld_q <= in_acc && id_hit;
      if (wr_en)      ent_vld_q[s1_idx_q] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_idx_q   <= in_idx;
      s1_ang_q   <= angle_raw_i;
      s1_speed_q <= speed_raw_i;
      s1_cur_q   <= cur_val;
      s1_temp_q  <= temp_raw_i;
      rdata_q    <= mem_q[in_idx];
      s1_rvld_q  <= ent_vld_q[in_idx];
      // same motor written this edge: take it from the write-back register
      s1_fwd_q   <= wr_en && (s1_idx_q == in_idx);
    end
    if (wr_en) begin
      mem_q[s1_idx_q] <= new_rec;
      wb_q            <= new_rec;
    end
  end

  // ---------------- stage 1: read-modify-write ----------------
  mftt_pkg::rec_t              cur_rec;
  logic                        init;
  logic signed [mftt_pkg::AngW:0] step;
  logic [mftt_pkg::TurnW-1:0]  turns_nx;
  logic [mftt_pkg::TotW-1:0]   total_nx;

  assign wr_en = s1_vld_q && s1_adv;

  always_comb begin
    if (s1_fwd_q)       cur_rec = wb_q;
    else if (s1_rvld_q) cur_rec = rdata_q;
    else                cur_rec = '0;

    init = (cur_rec.cnt <= init_frames_q);
    step = $signed({1'b0, s1_ang_q}) - $signed({1'b0, cur_rec.angle});

    turns_nx = cur_rec.turns;
    if (step > mftt_pkg::STEP_HI)      turns_nx = cur_rec.turns - 32'd1;
    else if (step < mftt_pkg::STEP_LO) turns_nx = cur_rec.turns + 32'd1;

    total_nx = {{1{turns_nx[31]}}, turns_nx, 13'd0}
             + {30'd0, s1_ang_q} - {30'd0, cur_rec.offset};

    new_rec       = cur_rec;
    new_rec.cnt   = (cur_rec.cnt < mftt_pkg::CNT_MAX) ? cur_rec.cnt + 6'd1 : cur_rec.cnt;
    new_rec.angle = s1_ang_q;
    if (init) begin
      new_rec.offset = s1_ang_q;
    end else begin
      new_rec.speed   = s1_speed_q;
      new_rec.current = s1_cur_q;
      new_rec.temp    = s1_temp_q;
      new_rec.turns   = turns_nx;
      new_rec.total   = total_nx;
    end
  end

  // ---------------- output register ----------------
  logic out_vld_q;
  assign out_valid_o = out_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (s1_adv) begin
      out_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      motor_index_o   <= s1_idx_q[0];
      in_init_o       <= init;
      angle_now_o     <= new_rec.angle;
      speed_now_o     <= new_rec.speed;
      current_now_o   <= new_rec.current;
      temp_now_o      <= new_rec.temp;
      turns_o         <= new_rec.turns;
      multiturn_pos_o <= new_rec.total;
    end
  end

  // ---------------- assertions ----------------
  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_vld_q && out_vld_q && !out_ready_i |-> !in_ready_o)
    else $error("input taken while stage 1 is stalled");

  a_write_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |=> ent_vld_q[$past(s1_idx_q)])
    else $error("written entry not marked valid");

  a_new_result_from_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !$past(out_vld_q) |-> $past(s1_vld_q))
    else $error("result appeared without a stage 1 item");

  a_fwd_source_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_vld_q && s1_fwd_q |-> ent_vld_q[s1_idx_q])
    else $error("forwarded from an entry never written");

endmodule
